// ===== src/dvrt_pkg.sv =====
`timescale 1ns / 1ps

package dvrt_pkg;

   // Field widths of the request, response and CSR channels.
   localparam int KIND_W      = 2;
   localparam int NODE_W      = 4;
   localparam int DIST_W      = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_ADVERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

   // CSR indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SELF_ID  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFINITY = 1'd1;

   // Reset values of the CSRs.
   localparam logic [NODE_W-1:0] SELF_ID_RESET  = 4'd0;
   localparam logic [DIST_W-1:0] INFINITY_RESET = 8'd20;

   typedef struct packed {
      logic usable;
      logic deliver;
      logic resend;
      logic changed;
   } rsp_flags_type;

endpackage

// ===== src/distance_vector_route_table.sv =====
// A response is registered from the execute state, which follows acceptance of
// its request; no new request is taken until that state ends. Each request reads
// its table entry from the route RAM and writes it back there if it changed.
// A finished response waits in an output register and may stall the write-back.
// Reset (synchronous, active high) clears all valid marks and restores self_id 0
// and infinity_metric 20; the RAM contents need no clearing.
`timescale 1ns / 1ps

module distance_vector_route_table import dvrt_pkg::*; #(
   parameter int NODE_COUNT  = 16,
   parameter int METRIC_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [NODE_W-1:0]      req_dest_node,
   input  logic [NODE_W-1:0]      req_sender_node,
   input  logic [DIST_W-1:0]      req_adv_distance,
   input  logic                   req_link_up,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [NODE_W-1:0]      rsp_via_node,
   output logic [DIST_W-1:0]      rsp_route_distance,
   output logic                   rsp_route_usable,
   output logic                   rsp_deliver_local,
   output logic                   rsp_resend_table,
   output logic                   rsp_entry_changed,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int ENTRY_W = NODE_W + METRIC_BITS;

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type               state_ff, state_in;
   logic [NODE_COUNT-1:0]   valid_ff;
   logic [NODE_W-1:0]       self_id_ff;
   logic [DIST_W-1:0]       infinity_ff;

   logic [KIND_W-1:0]       kind_ff;
   logic [NODE_W-1:0]       dest_ff;
   logic [NODE_W-1:0]       sender_ff;
   logic [DIST_W-1:0]       adv_ff;
   logic                    up_ff;
   logic                    in_range_ff;

   logic                    rsp_valid_ff;
   logic [NODE_W-1:0]       rsp_hop_ff;
   logic [DIST_W-1:0]       rsp_dist_ff;
   rsp_flags_type           rsp_flags_ff;

   logic                    accept;
   logic                    out_free;
   logic                    exec_fire;
   logic                    ram_we;
   logic [IDX_W-1:0]        rd_idx;
   logic [IDX_W-1:0]        idx;
   logic [ENTRY_W-1:0]      rd_entry;
   logic [ENTRY_W-1:0]      wr_entry;
   logic                    entry_valid;
   logic [NODE_W-1:0]       new_hop;
   logic [METRIC_BITS-1:0]  new_metric;
   logic [NODE_W-1:0]       upd_hop;
   logic [DIST_W-1:0]       upd_dist;
   rsp_flags_type           upd_flags;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign exec_fire = (state_ff == ST_EXEC) && out_free;
   assign csr_ready = 1'b1;

   assign rd_idx      = IDX_W'(req_dest_node);
   assign idx         = IDX_W'(dest_ff);
   assign entry_valid = in_range_ff && valid_ff[idx];
   assign ram_we      = exec_fire && upd_flags.changed;
   assign wr_entry    = {new_hop, new_metric};

   dvrt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODE_COUNT)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (rd_idx),
      .rd_data (rd_entry)
   );

   dvrt_update #(
      .METRIC_BITS (METRIC_BITS)
   ) u_update (
      .kind            (kind_ff),
      .dest_node       (dest_ff),
      .sender_node     (sender_ff),
      .adv_distance    (adv_ff),
      .link_up         (up_ff),
      .in_range        (in_range_ff),
      .self_id         (self_id_ff),
      .infinity_metric (infinity_ff),
      .entry_valid     (entry_valid),
      .entry_hop       (rd_entry[ENTRY_W-1:METRIC_BITS]),
      .entry_metric    (rd_entry[METRIC_BITS-1:0]),
      .new_hop         (new_hop),
      .new_metric      (new_metric),
      .rsp_hop         (upd_hop),
      .rsp_distance    (upd_dist),
      .rsp_flags       (upd_flags)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         self_id_ff   <= SELF_ID_RESET;
         infinity_ff  <= INFINITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SELF_ID:  self_id_ff  <= csr_wdata[NODE_W-1:0];
               CSR_INFINITY: infinity_ff <= csr_wdata[DIST_W-1:0];
               default: begin
               end
            endcase
         end
         if (ram_we) begin
            valid_ff[idx] <= 1'b1;
         end
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
            rsp_hop_ff   <= upd_hop;
            rsp_dist_ff  <= upd_dist;
            rsp_flags_ff <= upd_flags;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_kind;
         dest_ff     <= req_dest_node;
         sender_ff   <= req_sender_node;
         adv_ff      <= req_adv_distance;
         up_ff       <= req_link_up;
         in_range_ff <= (int'(req_dest_node) < NODE_COUNT);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_via_node       = rsp_hop_ff;
   assign rsp_route_distance = rsp_dist_ff;
   assign rsp_route_usable   = rsp_flags_ff.usable;
   assign rsp_deliver_local  = rsp_flags_ff.deliver;
   assign rsp_resend_table   = rsp_flags_ff.resend;
   assign rsp_entry_changed  = rsp_flags_ff.changed;

`ifndef SYNTHESIS
   // A response only appears right after the execute state.
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response appeared without a write-back cycle");

   // Every RAM write leaves the entry marked valid.
   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> valid_ff[idx])
      else $error("route entry written but not marked valid");

   // A lookup for this node never modifies the table.
   a_local_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flags_ff.deliver) |-> !rsp_flags_ff.changed)
      else $error("local delivery reported together with an entry change");
`endif

endmodule

// ===== src/dvrt_ram.sv =====
`timescale 1ns / 1ps

module dvrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dvrt_update.sv =====
`timescale 1ns / 1ps

module dvrt_update import dvrt_pkg::*; #(
   parameter int METRIC_BITS = 8
) (
   input  logic [KIND_W-1:0]      kind,
   input  logic [NODE_W-1:0]      dest_node,
   input  logic [NODE_W-1:0]      sender_node,
   input  logic [DIST_W-1:0]      adv_distance,
   input  logic                   link_up,
   input  logic                   in_range,
   input  logic [NODE_W-1:0]      self_id,
   input  logic [DIST_W-1:0]      infinity_metric,
   input  logic                   entry_valid,
   input  logic [NODE_W-1:0]      entry_hop,
   input  logic [METRIC_BITS-1:0] entry_metric,
   output logic [NODE_W-1:0]      new_hop,
   output logic [METRIC_BITS-1:0] new_metric,
   output logic [NODE_W-1:0]      rsp_hop,
   output logic [DIST_W-1:0]      rsp_distance,
   output rsp_flags_type          rsp_flags
);

   // Wide enough for a stored metric and for an advertised distance plus one.
   localparam int CW = (METRIC_BITS > DIST_W + 1) ? METRIC_BITS : DIST_W + 1;
   localparam logic [CW-1:0] METRIC_MAX = CW'((64'd1 << METRIC_BITS) - 64'd1);

   logic [CW-1:0] inf_w;
   logic [CW-1:0] sat;
   logic [CW-1:0] cand_raw;
   logic [CW-1:0] cand;
   logic [CW-1:0] one;
   logic [CW-1:0] met_w;
   logic          at_inf;
   logic          is_self;
   logic          nv;
   logic [NODE_W-1:0] nh;
   logic [CW-1:0] nm;
   logic          resend;
   logic          changed;
   logic          deliver;
   logic          shown;

   assign inf_w    = CW'(infinity_metric);
   assign sat      = (inf_w < METRIC_MAX) ? inf_w : METRIC_MAX;
   assign cand_raw = CW'(adv_distance) + CW'(1);
   assign cand     = (cand_raw > sat) ? sat : cand_raw;
   assign one      = (sat == '0) ? '0 : CW'(1);
   assign met_w    = CW'(entry_metric);
   assign at_inf   = (adv_distance >= infinity_metric);
   assign is_self  = (dest_node == self_id);

   always_comb begin
      nv      = entry_valid;
      nh      = entry_hop;
      nm      = met_w;
      resend  = 1'b0;
      changed = 1'b0;
      deliver = 1'b0;
      case (kind)
         KIND_ADVERT: begin
            if ((!entry_valid || met_w > cand_raw) && !is_self) begin
               nv      = 1'b1;
               nh      = sender_node;
               nm      = cand;
               changed = 1'b1;
               resend  = 1'b1;
            end else if (at_inf && entry_valid && entry_hop == sender_node) begin
               nm      = sat;
               changed = 1'b1;
               resend  = 1'b1;
            end else if (at_inf) begin
               resend  = 1'b1;
            end
         end
         KIND_LINK: begin
            if (link_up) begin
               nv      = 1'b1;
               nh      = dest_node;
               changed = 1'b1;
               if (is_self) begin
                  nm = '0;
               end else begin
                  nm     = one;
                  resend = !(entry_valid && met_w == CW'(1));
               end
            end else if (entry_valid) begin
               nm      = sat;
               changed = 1'b1;
               resend  = 1'b1;
            end
         end
         KIND_LOOKUP: begin
            deliver = is_self;
         end
         default: begin
         end
      endcase
   end

   // A destination outside the table reports nothing and writes nothing.
   assign shown        = nv && in_range;
   assign new_hop      = nh;
   assign new_metric   = nm[METRIC_BITS-1:0];
   assign rsp_hop      = shown ? nh : '0;
   assign rsp_distance = shown ? DIST_W'(nm) : '0;

   assign rsp_flags.usable  = shown && (nm < inf_w);
   assign rsp_flags.deliver = deliver && in_range;
   assign rsp_flags.resend  = resend && in_range;
   assign rsp_flags.changed = changed && in_range;

endmodule
